FILE: rtl/core/hkcdm_pkg.sv
package hkcdm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HUE_LOW      = 3'd0,
    REG_HUE_HIGH     = 3'd1,
    REG_REACH        = 3'd2,
    REG_FRAME_WIDTH  = 3'd3,
    REG_FRAME_HEIGHT = 3'd4
  } cfg_reg_t;

  localparam int          CFG_DW   = 11;
  localparam int          PIX_W    = 24;
  localparam logic [23:0] WHITE    = 24'hFF_FFFF;
  localparam int          OQ_DEPTH = 3;

  typedef struct packed {
    logic              last;
    logic              near;
    logic [PIX_W-1:0]  pix;
  } res_t;

endpackage

FILE: rtl/core/hkcdm_ram.sv
module hkcdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

FILE: rtl/core/hue_key_cross_dilate_mask.sv
// Hue-keyed mask with cross dilation. Pixels stream in raster order, one item
// per clock while in_tready is high, and results stream out at the same rate,
// trailing the input by reach rows. A pixel passes its edge BGR value when its
// hue, or the hue of a pixel 1..reach away to the left, right, above or below
// inside the frame, is within [hue_low, hue_high]; all other pixels come out
// white. After the last real row, feed reach rows of flush items (tuser = 1) to
// drain the frame; the result carrying tlast is the final pixel and the next
// item starts a new frame. Writing reach, frame_width or frame_height restarts
// the frame. The per-column history (2*MAX_REACH+1 hue flags and MAX_REACH+1
// edge pixels) sits in one dual-read RAM: each item reads its own column and
// a look-ahead column and writes its column back in the next cycle, with a
// one-deep bypass for back-to-back hits. Items pass stage 1 into a three-entry
// output queue that keeps input flowing while out_tready is low, until full.
module hue_key_cross_dilate_mask #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_REACH  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: hue[7:0], edge_blue[15:8], edge_green[23:16], edge_red[31:24]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,   // kind: 0 pixel, 1 flush
  // out_tdata: out_blue[7:0], out_green[15:8], out_red[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tuser,  // near_ball
  output logic        out_tlast,  // last pixel of frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + MAX_REACH + 1);
  localparam int RRW = $clog2(MAX_REACH + 1);
  localparam int FL  = 2 * MAX_REACH + 1;                      // flag history bits
  localparam int EL  = hkcdm_pkg::PIX_W * (MAX_REACH + 1);     // edge history bits
  localparam int MW  = FL + EL;
  localparam int RST_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int RST_H = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;
  localparam int RST_R = (1 > MAX_REACH) ? MAX_REACH : 1;

  // ---------------- configuration ----------------
  logic [7:0]     hue_low_r, hue_high_r;
  logic [RRW-1:0] reach_r;
  logic [WW-1:0]  width_r;
  logic [HW-1:0]  height_r;
  logic [RRW-1:0] hreach;     // horizontal reach, min(reach, width-1)
  logic           cfg_we, restart;
  logic [WW-1:0]  cfg_w;
  logic [HW-1:0]  cfg_h;
  logic [RRW-1:0] cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    // clamp into the supported geometry; a zero width or height acts as one
    if (cfg_data == '0) cfg_w = WW'(1);
    else if ({21'd0, cfg_data} > MAX_WIDTH) cfg_w = WW'(MAX_WIDTH);
    else cfg_w = WW'({21'd0, cfg_data});
    if (cfg_data == '0) cfg_h = HW'(1);
    else if ({21'd0, cfg_data} > MAX_HEIGHT) cfg_h = HW'(MAX_HEIGHT);
    else cfg_h = HW'({21'd0, cfg_data});
    if ({29'd0, cfg_data[2:0]} > MAX_REACH) cfg_r = RRW'(MAX_REACH);
    else cfg_r = RRW'({29'd0, cfg_data[2:0]});
  end

  assign restart = cfg_we && (cfg_index == hkcdm_pkg::REG_REACH ||
                              cfg_index == hkcdm_pkg::REG_FRAME_WIDTH ||
                              cfg_index == hkcdm_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= 8'd0;
      hue_high_r <= 8'd20;
      reach_r    <= RRW'(RST_R);
      width_r    <= WW'(RST_W);
      height_r   <= HW'(RST_H);
    end else if (cfg_we) begin
      case (cfg_index)
        hkcdm_pkg::REG_HUE_LOW:      hue_low_r  <= cfg_data[7:0];
        hkcdm_pkg::REG_HUE_HIGH:     hue_high_r <= cfg_data[7:0];
        hkcdm_pkg::REG_REACH:        reach_r    <= cfg_r;
        hkcdm_pkg::REG_FRAME_WIDTH:  width_r    <= cfg_w;
        hkcdm_pkg::REG_FRAME_HEIGHT: height_r   <= cfg_h;
        default: ;
      endcase
    end
  end

  always_comb begin
    if ({{(32-RRW){1'b0}}, reach_r} + 1 > {{(32-WW){1'b0}}, width_r})
      hreach = RRW'(width_r - WW'(1));
    else
      hreach = reach_r;
  end

  // ---------------- stage 0: accept, position, RAM read ----------------
  logic           accept;
  logic [CW-1:0]  in_col_r, in_col_nxt;
  logic [RW-1:0]  in_row_r, in_row_nxt;
  logic           is_data, flag0, produce0, last0;
  logic [RW-1:0]  orow0;
  logic [WW:0]    la_sum;
  logic [CW-1:0]  la_addr;
  logic [23:0]    edge0;
  logic [MAX_REACH-1:0] left_ok0, right_ok0, up_ok0, down_ok0;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    is_data  = !in_tuser && ({{(32-RW){1'b0}}, in_row_r} < {{(32-HW){1'b0}}, height_r});
    flag0    = is_data && in_tdata[7:0] >= hue_low_r && in_tdata[7:0] <= hue_high_r;
    edge0    = is_data ? in_tdata[31:8] : hkcdm_pkg::WHITE;
    produce0 = {{(32-RW){1'b0}}, in_row_r} >= {{(32-RRW){1'b0}}, reach_r};
    orow0    = in_row_r - RW'(reach_r);
    last0    = produce0 &&
               ({{(32-RW){1'b0}}, orow0} == {{(32-HW){1'b0}}, height_r} - 1) &&
               ({{(32-CW){1'b0}}, in_col_r} == {{(32-WW){1'b0}}, width_r} - 1);
    // look-ahead column; wraps into the next row near the row end
    la_sum   = (WW+1)'(in_col_r) + (WW+1)'(hreach);
    if (la_sum >= (WW+1)'(width_r)) la_sum = la_sum - (WW+1)'(width_r);
    la_addr  = la_sum[CW-1:0];
    for (int d = 1; d <= MAX_REACH; d++) begin
      up_ok0[d-1]    = (d <= int'(reach_r)) && (d <= int'(orow0));
      down_ok0[d-1]  = (d <= int'(reach_r));
      left_ok0[d-1]  = (d <= int'(hreach)) && (d <= int'(in_col_r));
      right_ok0[d-1] = (d <= int'(hreach)) && (int'(in_col_r) + d < int'(width_r));
    end
    if (last0) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if ({{(32-CW){1'b0}}, in_col_r} + 1 >= {{(32-WW){1'b0}}, width_r}) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + RW'(1);
    end else begin
      in_col_nxt = in_col_r + CW'(1);
      in_row_nxt = in_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
    end else if (restart) begin
      in_col_r <= '0;
      in_row_r <= '0;
    end else if (accept) begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
    end
  end

  // ---------------- stage 1: modify, write back, evaluate ----------------
  logic                 s1_valid_r, s1_prod_r, s1_last_r, s1_flag_r;
  logic [23:0]          s1_edge_r;
  logic [CW-1:0]        s1_col_r;
  logic [MAX_REACH-1:0] s1_left_r, s1_right_r, s1_up_r, s1_down_r;
  logic [MW-1:0]        ra_data, rb_data, wr_word, fwd_word_r, word_a, word_b;
  logic                 fwd_a_r, fwd_b_r;
  logic [FL-1:0]        new_flags, sh_r, sh_nxt;
  logic [EL-1:0]        new_edges;
  logic                 ins, near;
  logic [23:0]          pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_prod_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s1_prod_r  <= accept && produce0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last_r  <= last0;
      s1_flag_r  <= flag0;
      s1_edge_r  <= edge0;
      s1_col_r   <= in_col_r;
      s1_left_r  <= left_ok0;
      s1_right_r <= right_ok0;
      s1_up_r    <= up_ok0;
      s1_down_r  <= down_ok0;
    end
    // bypass: a read at the same edge as the write sees the old entry
    fwd_a_r    <= s1_valid_r && (in_col_r == s1_col_r);
    fwd_b_r    <= s1_valid_r && (la_addr == s1_col_r);
    fwd_word_r <= wr_word;
    if (s1_valid_r) sh_r <= sh_nxt;
  end

  hkcdm_ram #(.WIDTH(MW), .DEPTH(MAX_WIDTH)) u_hist_ram (
    .clk     (clk),
    .we      (s1_valid_r),
    .waddr   (s1_col_r),
    .wdata   (wr_word),
    .ra_addr (in_col_r),
    .ra_data (ra_data),
    .rb_addr (la_addr),
    .rb_data (rb_data)
  );

  always_comb begin
    word_a    = fwd_a_r ? fwd_word_r : ra_data;
    word_b    = fwd_b_r ? fwd_word_r : rb_data;
    // bit k = flag of k rows above the current input row
    new_flags = {word_a[FL-2:0], s1_flag_r};
    new_edges = {word_a[FL +: EL-24], s1_edge_r};
    wr_word   = {new_edges, new_flags};
    // look-ahead flag of the output row
    if (reach_r == '0) ins = s1_flag_r;
    else ins = word_b[reach_r - RRW'(1)];
    sh_nxt = {sh_r[FL-2:0], ins};
    near   = new_flags[reach_r];
    for (int d = 1; d <= MAX_REACH; d++) begin
      if (s1_up_r[d-1])    near = near | new_flags[int'(reach_r) + d];
      if (s1_down_r[d-1])  near = near | new_flags[int'(reach_r) - d];
      if (s1_left_r[d-1])  near = near | sh_nxt[int'(hreach) + d];
      if (s1_right_r[d-1]) near = near | sh_nxt[int'(hreach) - d];
    end
    pix = near ? new_edges[24*int'(reach_r) +: 24] : hkcdm_pkg::WHITE;
  end

  // ---------------- output queue ----------------
  hkcdm_pkg::res_t q_r [hkcdm_pkg::OQ_DEPTH];
  logic [1:0] wp_r, rp_r, cnt_r;
  logic       push, pop;

  assign push = s1_prod_r;
  assign pop  = out_tvalid && out_tready;
  assign in_tready = ({1'b0, cnt_r} + {2'b00, s1_prod_r}) < 3'(hkcdm_pkg::OQ_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == 2'(hkcdm_pkg::OQ_DEPTH - 1)) ? 2'd0 : wp_r + 2'd1;
      if (pop)  rp_r <= (rp_r == 2'(hkcdm_pkg::OQ_DEPTH - 1)) ? 2'd0 : rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= '{last: s1_last_r, near: near, pix: pix};
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_r[rp_r].pix;
  assign out_tuser  = q_r[rp_r].near;
  assign out_tlast  = q_r[rp_r].last;

endmodule

FILE: rtl/core/hkcdm_checker.sv
module hkcdm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // masked pixels are white
  a_mask_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == hkcdm_pkg::WHITE)
    else $error("masked item not white");

  // nothing left over once reset is released
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled item changed");

endmodule

bind hue_key_cross_dilate_mask hkcdm_checker u_hkcdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
